[rtl/gda_pkg.sv]
// gda_pkg: constants and helper functions for the gregorian date unit
// no dependencies; used by gregorian_date_alu_core
package gda_pkg;

    localparam int unsigned YEAR_MAX_DEFAULT = 9999;

    // request codes
    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_CMP = 1'b1;

    // order codes
    localparam logic [1:0] ORD_EARLIER = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_LATER   = 2'd2;

    // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for x < 43699
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int unsigned DIV100_SHIFT = 19;

    // floor(2^32 * 400 / 146097), year estimate from a day number
    localparam logic [23:0] YEAR_RECIP = 24'd11759221;
    localparam int unsigned YEAR_RECIP_SHIFT = 32;

    localparam logic signed [25:0] DIFF_MAX = 26'sd4194303;
    localparam logic signed [25:0] DIFF_MIN = -26'sd4194304;

    function automatic logic [15:0] div100(input logic [16:0] x);
        logic [29:0] p;
        begin
            p = 30'(x) * 30'(DIV100_MUL);
            div100 = 16'(p >> DIV100_SHIFT);
        end
    endfunction

    function automatic logic leap_year(input logic [15:0] y);
        logic [15:0] q;
        logic [22:0] back;
        logic        cent;
        begin
            q    = div100({1'b0, y});
            back = 23'(q) * 23'd100;
            cent = (back == 23'(y));
            leap_year = ((y[1:0] == 2'b00) && !cent) || (cent && (q[1:0] == 2'b00));
        end
    endfunction

    // days of all years before year y, year 0 leap
    function automatic logic [23:0] year_start(input logic [15:0] y);
        logic [16:0] c4;
        logic [15:0] c100;
        logic [15:0] c400;
        logic [16:0] y399;
        logic [24:0] acc;
        begin
            c4   = (17'(y) + 17'd3) >> 2;
            c100 = div100(17'(y) + 17'd99);
            y399 = 17'(y) + 17'd399;
            c400 = div100(17'(y399 >> 2));
            acc  = 25'(y) * 25'd365 + 25'(c4) - 25'(c100) + 25'(c400);
            year_start = acc[23:0];
        end
    endfunction

    // days before month m in a common year, months beyond 12 keep 31 days
    function automatic logic [8:0] days_before(input logic [3:0] m);
        begin
            unique case (m)
                4'd0:    days_before = 9'd0;
                4'd1:    days_before = 9'd0;
                4'd2:    days_before = 9'd31;
                4'd3:    days_before = 9'd59;
                4'd4:    days_before = 9'd90;
                4'd5:    days_before = 9'd120;
                4'd6:    days_before = 9'd151;
                4'd7:    days_before = 9'd181;
                4'd8:    days_before = 9'd212;
                4'd9:    days_before = 9'd243;
                4'd10:   days_before = 9'd273;
                4'd11:   days_before = 9'd304;
                4'd12:   days_before = 9'd334;
                4'd13:   days_before = 9'd365;
                4'd14:   days_before = 9'd396;
                default: days_before = 9'd427;
            endcase
        end
    endfunction

endpackage

[rtl/gregorian_date_alu_core.sv]
// gregorian_date_alu_core: pipelined proleptic gregorian date add / compare unit
// depends on gda_pkg (constants, leap rule, year start, month table)
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready  | req_type, day_a..year_b, add_count
//  out     | output    | out_valid / out_ready| res_day, res_month, res_year,
//          |           |                      | day_difference, order
//
//  six register stages, one transaction per cycle while the output is not stalled
//  the depth is set by the day number to date inversion: year estimate
//  multiply, candidate year starts, year select, month search
//  rst_n clears the stage valid bits only, payload registers are not reset
//  a stall holds the occupied stages from the output back to the first bubble, bubbles are squeezed out
module gregorian_date_alu_core #(
    parameter int unsigned YEAR_MAX = gda_pkg::YEAR_MAX_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [4:0]         day_a,
    input  logic [3:0]         month_a,
    input  logic [13:0]        year_a,
    input  logic [4:0]         day_b,
    input  logic [3:0]         month_b,
    input  logic [13:0]        year_b,
    input  logic [15:0]        add_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [4:0]         res_day,
    output logic [3:0]         res_month,
    output logic [13:0]        res_year,
    output logic signed [22:0] day_difference,
    output logic [1:0]         order
);

    // stage valid bits and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !v6_reg || out_ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: clamp years, leap flags, year starts, passthrough check
    // ---------------------------------------------------------------
    logic [15:0] ya_c, yb_c;
    logic [16:0] add_day;
    logic        lp_a_c;
    logic [4:0]  len_a;
    logic        pass_c;

    always_comb
    begin
        ya_c    = ({2'b00, year_a} > YEAR_MAX[15:0]) ? YEAR_MAX[15:0] : {2'b00, year_a};
        yb_c    = ({2'b00, year_b} > YEAR_MAX[15:0]) ? YEAR_MAX[15:0] : {2'b00, year_b};
        add_day = 17'(day_a) + 17'(add_count);
        lp_a_c  = gda_pkg::leap_year(ya_c);
        if (month_a == 4'd2)
            len_a = lp_a_c ? 5'd29 : 5'd28;
        else if (month_a == 4'd4 || month_a == 4'd6 || month_a == 4'd9 || month_a == 4'd11)
            len_a = 5'd30;
        else
            len_a = 5'd31;
        // no month roll at all: the day becomes day plus count, month and clamped year come back as given
        pass_c = (add_day <= 17'(len_a));
    end

    logic        s1_op_reg, s1_pass_reg, s1_lpa_reg, s1_lpb_reg;
    logic [4:0]  s1_da_reg, s1_db_reg;
    logic [3:0]  s1_ma_reg, s1_mb_reg;
    logic [13:0] s1_ya_reg;
    logic [16:0] s1_addday_reg;
    logic [23:0] s1_ysa_reg, s1_ysb_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_op_reg     <= req_type;
            s1_pass_reg   <= pass_c;
            s1_lpa_reg    <= lp_a_c;
            s1_lpb_reg    <= gda_pkg::leap_year(yb_c);
            s1_da_reg     <= day_a;
            s1_db_reg     <= day_b;
            s1_ma_reg     <= month_a;
            s1_mb_reg     <= month_b;
            s1_ya_reg     <= ya_c[13:0];
            s1_addday_reg <= add_day;
            s1_ysa_reg    <= gda_pkg::year_start(ya_c);
            s1_ysb_reg    <= gda_pkg::year_start(yb_c);
        end
    end

    // ---------------------------------------------------------------
    // stage 2: day numbers for compare, zero based day number for add
    // ---------------------------------------------------------------
    logic [23:0] dna_c, dnb_c, d0_c;
    logic [23:0] add_off;

    always_comb
    begin
        dna_c = s1_ysa_reg + 24'(gda_pkg::days_before(s1_ma_reg))
              + 24'(s1_ma_reg > 4'd2 && s1_lpa_reg) + 24'(s1_da_reg);
        dnb_c = s1_ysb_reg + 24'(gda_pkg::days_before(s1_mb_reg))
              + 24'(s1_mb_reg > 4'd2 && s1_lpb_reg) + 24'(s1_db_reg);
        // month zero rolls one 31-day month into january of the same year,
        // months 13..15 roll one 31-day month into january of the next year
        if (s1_ma_reg == 4'd0)
            add_off = 24'(s1_addday_reg) - 24'd31;
        else if (s1_ma_reg > 4'd12)
            add_off = 24'(s1_addday_reg) + 24'd334 + 24'(s1_lpa_reg);
        else
            add_off = 24'(s1_addday_reg) + 24'(gda_pkg::days_before(s1_ma_reg))
                    + 24'(s1_ma_reg > 4'd2 && s1_lpa_reg);
        d0_c = s1_ysa_reg + add_off - 24'd1;
    end

    logic        s2_op_reg, s2_pass_reg;
    logic [4:0]  s2_pday_reg;
    logic [3:0]  s2_pmon_reg;
    logic [13:0] s2_pyr_reg;
    logic [23:0] s2_dna_reg, s2_dnb_reg, s2_d0_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_pass_reg <= s1_pass_reg;
            s2_pday_reg <= s1_addday_reg[4:0];
            s2_pmon_reg <= s1_ma_reg;
            s2_pyr_reg  <= s1_ya_reg;
            s2_dna_reg  <= dna_c;
            s2_dnb_reg  <= dnb_c;
            s2_d0_reg   <= d0_c;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: difference and order, year estimate
    // ---------------------------------------------------------------
    logic signed [25:0] diff_c;
    logic [22:0]        sat_c;
    logic [1:0]         ord_c;
    logic [47:0]        est_prod;

    always_comb
    begin
        diff_c = $signed({2'b00, s2_dna_reg}) - $signed({2'b00, s2_dnb_reg});
        if (diff_c > gda_pkg::DIFF_MAX)
            sat_c = 23'h3FFFFF;
        else if (diff_c < gda_pkg::DIFF_MIN)
            sat_c = 23'h400000;
        else
            sat_c = diff_c[22:0];
        if (diff_c < 26'sd0)
            ord_c = gda_pkg::ORD_EARLIER;
        else if (diff_c == 26'sd0)
            ord_c = gda_pkg::ORD_EQUAL;
        else
            ord_c = gda_pkg::ORD_LATER;
        est_prod = 48'(s2_d0_reg) * 48'(gda_pkg::YEAR_RECIP);
    end

    logic        s3_op_reg, s3_pass_reg;
    logic [4:0]  s3_pday_reg;
    logic [3:0]  s3_pmon_reg;
    logic [13:0] s3_pyr_reg;
    logic [22:0] s3_diff_reg;
    logic [1:0]  s3_ord_reg;
    logic [23:0] s3_d0_reg;
    logic [15:0] s3_est_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_op_reg   <= s2_op_reg;
            s3_pass_reg <= s2_pass_reg;
            s3_pday_reg <= s2_pday_reg;
            s3_pmon_reg <= s2_pmon_reg;
            s3_pyr_reg  <= s2_pyr_reg;
            s3_diff_reg <= sat_c;
            s3_ord_reg  <= ord_c;
            s3_d0_reg   <= s2_d0_reg;
            s3_est_reg  <= 16'(est_prod >> gda_pkg::YEAR_RECIP_SHIFT);
        end
    end

    // ---------------------------------------------------------------
    // stage 4: year start and leap flag of estimate - 1, estimate, + 1
    // ---------------------------------------------------------------
    logic [15:0] cand_yr [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            cand_yr[j] = s3_est_reg + 16'(j) - 16'd1;
    end

    logic        s4_op_reg, s4_pass_reg;
    logic [4:0]  s4_pday_reg;
    logic [3:0]  s4_pmon_reg;
    logic [13:0] s4_pyr_reg;
    logic [22:0] s4_diff_reg;
    logic [1:0]  s4_ord_reg;
    logic [23:0] s4_d0_reg;
    logic [15:0] s4_est_reg;
    logic [23:0] s4_ys_reg [3];
    logic [2:0]  s4_lp_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_op_reg   <= s3_op_reg;
            s4_pass_reg <= s3_pass_reg;
            s4_pday_reg <= s3_pday_reg;
            s4_pmon_reg <= s3_pmon_reg;
            s4_pyr_reg  <= s3_pyr_reg;
            s4_diff_reg <= s3_diff_reg;
            s4_ord_reg  <= s3_ord_reg;
            s4_d0_reg   <= s3_d0_reg;
            s4_est_reg  <= s3_est_reg;
            for (int j = 0; j < 3; j++)
            begin
                s4_ys_reg[j] <= gda_pkg::year_start(cand_yr[j]);
                s4_lp_reg[j] <= gda_pkg::leap_year(cand_yr[j]);
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 5: pick the year whose start is the last one not past d0
    // ---------------------------------------------------------------
    logic [15:0] yr_sel;
    logic [23:0] ys_sel;
    logic        lp_sel;

    always_comb
    begin
        priority if (s4_d0_reg < s4_ys_reg[1])
        begin
            yr_sel = s4_est_reg - 16'd1;
            ys_sel = s4_ys_reg[0];
            lp_sel = s4_lp_reg[0];
        end
        else if (s4_d0_reg >= s4_ys_reg[2])
        begin
            yr_sel = s4_est_reg + 16'd1;
            ys_sel = s4_ys_reg[2];
            lp_sel = s4_lp_reg[2];
        end
        else
        begin
            yr_sel = s4_est_reg;
            ys_sel = s4_ys_reg[1];
            lp_sel = s4_lp_reg[1];
        end
    end

    logic        s5_op_reg, s5_pass_reg, s5_lp_reg;
    logic [4:0]  s5_pday_reg;
    logic [3:0]  s5_pmon_reg;
    logic [13:0] s5_pyr_reg;
    logic [22:0] s5_diff_reg;
    logic [1:0]  s5_ord_reg;
    logic [13:0] s5_yr_reg;
    logic [8:0]  s5_doy_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_op_reg   <= s4_op_reg;
            s5_pass_reg <= s4_pass_reg;
            s5_lp_reg   <= lp_sel;
            s5_pday_reg <= s4_pday_reg;
            s5_pmon_reg <= s4_pmon_reg;
            s5_pyr_reg  <= s4_pyr_reg;
            s5_diff_reg <= s4_diff_reg;
            s5_ord_reg  <= s4_ord_reg;
            s5_yr_reg   <= yr_sel[13:0];
            s5_doy_reg  <= 9'(s4_d0_reg - ys_sel);
        end
    end

    // ---------------------------------------------------------------
    // stage 6: month search over the day of year, output register
    // ---------------------------------------------------------------
    logic [3:0] mon_c;
    logic [8:0] cum_c;
    logic [8:0] cum_i;
    logic [4:0] day_c;
    logic [4:0] o_day;
    logic [3:0] o_mon;
    logic [13:0] o_yr;
    logic [22:0] o_diff;
    logic [1:0]  o_ord;

    always_comb
    begin
        mon_c = 4'd1;
        cum_c = 9'd0;
        for (int i = 2; i <= 12; i++)
        begin
            cum_i = gda_pkg::days_before(4'(i)) + 9'(s5_lp_reg && (i > 2));
            if (s5_doy_reg >= cum_i)
            begin
                mon_c = 4'(i);
                cum_c = cum_i;
            end
        end
        day_c = 5'(s5_doy_reg - cum_c + 9'd1);

        o_day  = 5'd0;
        o_mon  = 4'd0;
        o_yr   = 14'd0;
        o_diff = 23'd0;
        o_ord  = gda_pkg::ORD_EARLIER;
        if (s5_op_reg == gda_pkg::REQ_CMP)
        begin
            o_diff = s5_diff_reg;
            o_ord  = s5_ord_reg;
        end
        else if (s5_pass_reg)
        begin
            o_day = s5_pday_reg;
            o_mon = s5_pmon_reg;
            o_yr  = s5_pyr_reg;
        end
        else
        begin
            o_day = day_c;
            o_mon = mon_c;
            o_yr  = s5_yr_reg;
        end
    end

    logic        s6_conv_reg;
    logic [4:0]  s6_day_reg;
    logic [3:0]  s6_mon_reg;
    logic [13:0] s6_yr_reg;
    logic [22:0] s6_diff_reg;
    logic [1:0]  s6_ord_reg;

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            s6_conv_reg <= (s5_op_reg == gda_pkg::REQ_ADD) && !s5_pass_reg;
            s6_day_reg  <= o_day;
            s6_mon_reg  <= o_mon;
            s6_yr_reg   <= o_yr;
            s6_diff_reg <= o_diff;
            s6_ord_reg  <= o_ord;
        end
    end

    assign out_valid      = v6_reg;
    assign res_day        = s6_day_reg;
    assign res_month      = s6_mon_reg;
    assign res_year       = s6_yr_reg;
    assign day_difference = $signed(s6_diff_reg);
    assign order          = s6_ord_reg;

`ifndef NO_ASSERTIONS
    // order code three is never produced
    a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg |-> (s6_ord_reg != 2'd3))
        else $error("order code out of range");

    // a rolled date always lands in a real month with a nonzero day
    a_conv_month: assert property (@(posedge clk) disable iff (!rst_n)
        (v6_reg && s6_conv_reg) |->
            (s6_mon_reg >= 4'd1 && s6_mon_reg <= 4'd12 && s6_day_reg != 5'd0))
        else $error("rolled date has bad month or day");

    // an accepted transaction always occupies the first stage next cycle
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted transaction lost at pipeline entry");

    // a stalled output stage keeps its transaction
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v6_reg && !out_ready) |=> (v6_reg && $stable(s6_diff_reg) && $stable(s6_yr_reg)))
        else $error("output stage changed under stall");
`endif

endmodule

[tb/gregorian_date_alu_core_tb.sv]
// gregorian_date_alu_core_tb: self-checking bench for the date add / compare unit
// depends on gda_pkg and gregorian_date_alu_core; predicts each transaction
// in-bench and matches results in order through a small scoreboard class
module gregorian_date_alu_core_tb;

    localparam int unsigned YEAR_LIMIT = 9999;
    localparam int          DIFF_HI    = 4194303;
    localparam int          DIFF_LO    = -4194304;
    localparam int          N_RANDOM   = 1250;
    localparam int          IDLE_LIMIT = 20000;
    localparam int          LATENCY    = 6;

    typedef struct packed {
        logic [4:0]         day;
        logic [3:0]         month;
        logic [13:0]        year;
        logic signed [22:0] diff;
        logic [1:0]         ord;
    } date_result_t;

    // leap rule on a wide year, the add path lets the year run past the 9999 clamp
    function automatic bit is_leap(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        if (m == 2) return is_leap(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    // day number from year 0, months beyond 12 keep counting 31 days each
    function automatic longint serial_day(input int unsigned d, input int unsigned m,
                                          input int unsigned y);
        longint n;
        int unsigned before_m;
        n = longint'(y) * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        if (m <= 1) before_m = 0;
        else if (m <= 12)
        begin
            before_m = 0;
            for (int unsigned k = 1; k < m; k++) before_m += month_days(k, 1);
        end
        else before_m = 365 + 31 * (m - 13);
        n += before_m;
        if (m > 2 && is_leap(y)) n += 1;
        return n + d;
    endfunction

    function automatic date_result_t predict_date_op(
        input logic rq, input logic [4:0] da, input logic [3:0] ma, input logic [13:0] ya,
        input logic [4:0] db, input logic [3:0] mb, input logic [13:0] yb,
        input logic [15:0] cnt);
        date_result_t r;
        int unsigned day, mon, yr, yra, yrb;
        longint diff, sat;
        r = '0;
        yra = (ya > YEAR_LIMIT) ? YEAR_LIMIT : ya;
        yrb = (yb > YEAR_LIMIT) ? YEAR_LIMIT : yb;
        if (rq == gda_pkg::REQ_ADD)
        begin
            day = da + cnt;
            mon = ma;
            yr  = yra;
            while (day > month_days(mon, yr))
            begin
                day -= month_days(mon, yr);
                mon++;
                if (mon > 12)
                begin
                    mon = 1;
                    yr++;
                end
            end
            r.day   = day[4:0];
            r.month = mon[3:0];
            r.year  = yr[13:0];
        end
        else
        begin
            diff = serial_day(da, ma, yra) - serial_day(db, mb, yrb);
            sat  = diff > DIFF_HI ? DIFF_HI : (diff < DIFF_LO ? DIFF_LO : diff);
            r.diff = sat[22:0];
            r.ord  = diff < 0 ? gda_pkg::ORD_EARLIER
                   : (diff == 0 ? gda_pkg::ORD_EQUAL : gda_pkg::ORD_LATER);
        end
        return r;
    endfunction

    class date_scoreboard;
        date_result_t pending[$];
        int mismatches;

        function void note_request(date_result_t exp_r);
            pending.push_back(exp_r);
        endfunction

        function void check_result(date_result_t got);
            date_result_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result day=%0d month=%0d year=%0d %s%0d order=%0d",
                             got.day, got.month, got.year, "diff=", got.diff, got.ord);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp d/m/y=%0d/%0d/%0d diff=%0d ord=%0d, %s%0d/%0d/%0d%s",
                             exp_r.day, exp_r.month, exp_r.year, exp_r.diff, exp_r.ord,
                             "got d/m/y=", got.day, got.month, got.year,
                             $sformatf(" diff=%0d ord=%0d", got.diff, got.ord));
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               req_type;
    logic [4:0]         day_a;
    logic [3:0]         month_a;
    logic [13:0]        year_a;
    logic [4:0]         day_b;
    logic [3:0]         month_b;
    logic [13:0]        year_b;
    logic [15:0]        add_count;
    logic               out_valid;
    logic               out_ready;
    logic [4:0]         res_day;
    logic [3:0]         res_month;
    logic [13:0]        res_year;
    logic signed [22:0] day_difference;
    logic [1:0]         order;

    date_scoreboard sb;
    bit             hold_off_out;     // long receiver stall so the pipe backs up
    int             idle_cycles = 0;

    gregorian_date_alu_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .day_a(day_a), .month_a(month_a), .year_a(year_a),
        .day_b(day_b), .month_b(month_b), .year_b(year_b), .add_count(add_count),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_day(res_day), .res_month(res_month), .res_year(res_year),
        .day_difference(day_difference), .order(order)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one transaction and hold it until accepted
    task automatic send_request(input logic rq, input logic [4:0] da, input logic [3:0] ma,
                                input logic [13:0] ya, input logic [4:0] db,
                                input logic [3:0] mb, input logic [13:0] yb,
                                input logic [15:0] cnt);
        req_type  <= rq;
        day_a     <= da;
        month_a   <= ma;
        year_a    <= ya;
        day_b     <= db;
        month_b   <= mb;
        year_b    <= yb;
        add_count <= cnt;
        in_valid  <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    // gap after an accepted transaction; valid drops only when a gap follows
    task automatic pause_sender();
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic logic [13:0] rand_year();
        int p;
        p = $urandom_range(0, 9);
        if (p < 6) return 14'($urandom_range(0, 9999));
        if (p < 8) return 14'($urandom_range(1500, 2500));
        return 14'($urandom_range(0, 16383));
    endfunction

    task automatic send_random();
        logic rq;
        logic [4:0] da, db;
        logic [3:0] ma, mb;
        logic [13:0] ya, yb;
        logic [15:0] cnt;
        int p;
        rq = 1'($urandom_range(0, 1));
        p  = $urandom_range(0, 9);
        // mostly well-formed dates, some out-of-range fields as noise
        if (p < 8)
        begin
            ma = 4'($urandom_range(1, 12));
            da = 5'($urandom_range(1, 28 + (ma == 2 ? 1 : 3)));
            mb = 4'($urandom_range(1, 12));
            db = 5'($urandom_range(1, 28));
        end
        else
        begin
            ma = 4'($urandom); da = 5'($urandom); mb = 4'($urandom); db = 5'($urandom);
        end
        ya = rand_year();
        yb = ($urandom_range(0, 3) == 0) ? ya : rand_year();
        if ($urandom_range(0, 7) == 0)
        begin
            da = db; ma = mb; ya = yb;
        end
        p = $urandom_range(0, 9);
        if (p < 5) cnt = 16'($urandom_range(0, 400));
        else if (p < 9) cnt = 16'($urandom);
        else cnt = 16'hffff;
        send_request(rq, da, ma, ya, db, mb, yb, cnt);
    endtask

    // predictor hook: every accepted request gets its expectation
    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
            sb.note_request(predict_date_op(req_type, day_a, month_a, year_a,
                                            day_b, month_b, year_b, add_count));

    // result side: every accepted result is matched against the oldest expectation
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result({res_day, res_month, res_year, day_difference, order});

    // receiver stalls, with one long hold-off while the sender keeps offering
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_out && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (60) @(posedge clk);
            end
            out_ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    // watchdog on cycles with no accepted transaction at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int extra;
        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        req_type  <= gda_pkg::REQ_ADD;
        day_a     <= '0; month_a <= '0; year_a <= '0;
        day_b     <= '0; month_b <= '0; year_b <= '0;
        add_count <= '0;
        hold_off_out = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, leap corners, odd months and days, year clamping
        send_request(gda_pkg::REQ_ADD, 5'd1, 4'd1, 14'd0, 5'd0, 4'd0, 14'd0, 16'd0);
        send_request(gda_pkg::REQ_ADD, 5'd28, 4'd2, 14'd2000, 5'd0, 4'd0, 14'd0, 16'd1);
        send_request(gda_pkg::REQ_ADD, 5'd28, 4'd2, 14'd1900, 5'd0, 4'd0, 14'd0, 16'd1);
        send_request(gda_pkg::REQ_ADD, 5'd31, 4'd12, 14'd9999, 5'd0, 4'd0, 14'd0, 16'hffff);
        send_request(gda_pkg::REQ_ADD, 5'd31, 4'd15, 14'h3fff, 5'd31, 4'd15, 14'h3fff,
                     16'hffff);
        send_request(gda_pkg::REQ_ADD, 5'd0, 4'd0, 14'd100, 5'd0, 4'd0, 14'd0, 16'd0);
        send_request(gda_pkg::REQ_ADD, 5'd31, 4'd13, 14'd5, 5'd0, 4'd0, 14'd0, 16'd40);
        send_request(gda_pkg::REQ_ADD, 5'd31, 4'd4, 14'd2023, 5'd0, 4'd0, 14'd0, 16'd0);
        send_request(gda_pkg::REQ_CMP, 5'd1, 4'd1, 14'd0, 5'd1, 4'd1, 14'd0, 16'd0);
        send_request(gda_pkg::REQ_CMP, 5'd31, 4'd12, 14'd9999, 5'd1, 4'd1, 14'd0, 16'd0);
        send_request(gda_pkg::REQ_CMP, 5'd1, 4'd1, 14'd0, 5'd31, 4'd12, 14'd9999, 16'd0);
        send_request(gda_pkg::REQ_CMP, 5'd31, 4'd15, 14'h3fff, 5'd0, 4'd0, 14'd0, 16'hffff);
        send_request(gda_pkg::REQ_CMP, 5'd0, 4'd0, 14'd0, 5'd31, 4'd15, 14'h3fff, 16'd0);
        send_request(gda_pkg::REQ_CMP, 5'd1, 4'd3, 14'd2000, 5'd29, 4'd2, 14'd2000, 16'd0);
        send_request(gda_pkg::REQ_CMP, 5'd1, 4'd3, 14'd1900, 5'd28, 4'd2, 14'd1900, 16'd0);
        send_request(gda_pkg::REQ_CMP, 5'd5, 4'd14, 14'd400, 5'd5, 4'd14, 14'd400, 16'd0);
        send_request(gda_pkg::REQ_CMP, 5'd31, 4'd2, 14'd2024, 5'd2, 4'd3, 14'd2024, 16'd0);
        send_request(gda_pkg::REQ_CMP, 5'd10, 4'd6, 14'd12000, 5'd10, 4'd6, 14'd9999, 16'd0);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2) hold_off_out = 1'b1;
            send_random();
            pause_sender();
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        extra = 0;
        while (extra < 4 * LATENCY)
        begin
            @(posedge clk);
            extra++;
        end
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[files.f]
rtl/gda_pkg.sv
rtl/gregorian_date_alu_core.sv
tb/gregorian_date_alu_core_tb.sv
